// ----- hw/rtl/ggs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the grid gradient stencil unit.
package ggs_pkg;

    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int GRAD_W     = 32;
    localparam int STEP_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_PANELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_PANELS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int SCALE_LAT   = 5;
    localparam int NUM_SLOTS   = 3;
    localparam int NUM_DIFF    = 6;

    // result slots of one job
    localparam logic [1:0] SLOT_UP   = 2'd0;
    localparam logic [1:0] SLOT_LEFT = 2'd1;
    localparam logic [1:0] SLOT_LAST = 2'd2;

    // difference lanes of one job
    localparam int D_UP_X   = 0;
    localparam int D_UP_Y   = 1;
    localparam int D_LEFT_X = 2;
    localparam int D_LEFT_Y = 3;
    localparam int D_LAST_X = 4;
    localparam int D_LAST_Y = 5;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] has;
        logic                 cx_up;
        logic                 cy_up;
        logic                 cx_left;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
    } t_job_ctl;

endpackage

// ----- hw/rtl/ggs_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read, read-first on collision.
module ggs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ggs_front.sv -----
`timescale 1ns / 1ps
// Front end: sample accept, raster counters, row stores, window and difference forming.
module ggs_front #(
    parameter int MAX_COLUMNS  = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [ggs_pkg::COL_W-1:0]                     i_x_panels,
    input  logic [ggs_pkg::ROW_W-1:0]                     i_y_panels,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]                       i_sample,
    input  logic [$clog2(ggs_pkg::QUEUE_DEPTH+1)-1:0]     i_queue_count,
    output logic                                          o_push,
    output ggs_pkg::t_job_ctl                             o_push_ctl,
    output logic [ggs_pkg::NUM_DIFF-1:0][SAMPLE_WIDTH:0]  o_push_diff
);

    localparam int AW      = $clog2(MAX_COLUMNS);
    localparam int DW      = SAMPLE_WIDTH + 1;
    localparam int CW      = $clog2(ggs_pkg::QUEUE_DEPTH + 1);
    localparam int COL_MAX = (1 << ggs_pkg::COL_W) - 1;
    localparam int X_LIMIT = (MAX_COLUMNS - 1 > COL_MAX) ? COL_MAX : MAX_COLUMNS - 1;

    function automatic logic [DW-1:0] f_diff(input logic [SAMPLE_WIDTH-1:0] a,
                                             input logic [SAMPLE_WIDTH-1:0] b);
        f_diff = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
    endfunction

    logic [ggs_pkg::COL_W-1:0] x_last;
    logic [ggs_pkg::ROW_W-1:0] y_last;
    logic                      accept;
    logic                      last_col;
    logic                      last_row;
    logic                      bank;
    logic [AW-1:0]             col_addr;
    logic [AW-1:0]             col_next_addr;

    logic [ggs_pkg::COL_W-1:0] r_col;
    logic [ggs_pkg::ROW_W-1:0] r_row;
    logic [SAMPLE_WIDTH-1:0]   r_win [3];
    logic [SAMPLE_WIDTH-1:0]   r_first [2];
    logic [SAMPLE_WIDTH-1:0]   r_pw0;
    logic [SAMPLE_WIDTH-1:0]   r_pw1;
    logic [SAMPLE_WIDTH-1:0]   ram_rdata [2];

    logic                      r_bv;
    logic [ggs_pkg::COL_W-1:0] r_b_col;
    logic [ggs_pkg::ROW_W-1:0] r_b_row;
    logic                      r_b_bank;
    logic                      r_b_col_zero;
    logic                      r_b_col_one;
    logic                      r_b_last_col;
    logic                      r_b_last_row;
    logic                      r_b_up;
    logic                      r_b_top2;

    logic                      pb;
    logic [SAMPLE_WIDTH-1:0]   q_c;
    logic [SAMPLE_WIDTH-1:0]   q_m;
    logic [SAMPLE_WIDTH-1:0]   q_p;
    logic [SAMPLE_WIDTH-1:0]   q_b;

    always_comb begin
        x_last = (i_x_panels == '0) ? ggs_pkg::COL_W'(1) : i_x_panels;
        if (x_last > ggs_pkg::COL_W'(X_LIMIT)) begin
            x_last = ggs_pkg::COL_W'(X_LIMIT);
        end
        y_last = (i_y_panels == '0) ? ggs_pkg::ROW_W'(1) : i_y_panels;
    end

    assign o_in_ready    = (i_queue_count + CW'(r_bv)) < CW'(ggs_pkg::QUEUE_DEPTH);
    assign accept        = i_in_valid && o_in_ready;
    assign last_col      = r_col >= x_last;
    assign last_row      = r_row >= y_last;
    assign bank          = r_row[0];
    assign col_addr      = AW'(r_col);
    assign col_next_addr = AW'({1'b0, r_col} + (ggs_pkg::COL_W + 1)'(1));

    // bank of the current row: read old entry (two rows up) and overwrite;
    // other bank: read one column ahead in the previous row
    for (genvar g = 0; g < 2; g++) begin : g_bank
        ggs_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (MAX_COLUMNS)
        ) u_row_store (
            .i_clk   (i_clk),
            .i_we    (accept && (bank == 1'(g))),
            .i_waddr (col_addr),
            .i_wdata (i_sample),
            .i_raddr ((bank == 1'(g)) ? col_addr : col_next_addr),
            .o_rdata (ram_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_bv  <= 1'b0;
        end else begin
            r_bv <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ggs_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + ggs_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0]     <= r_win[1];
            r_win[1]     <= r_win[2];
            r_win[2]     <= i_sample;
            if (r_col == '0) begin
                r_first[bank] <= i_sample;
            end
            r_b_col      <= r_col;
            r_b_row      <= r_row;
            r_b_bank     <= bank;
            r_b_col_zero <= r_col == '0;
            r_b_col_one  <= r_col == ggs_pkg::COL_W'(1);
            r_b_last_col <= last_col;
            r_b_last_row <= last_row;
            r_b_up       <= r_row != '0;
            r_b_top2     <= r_row == ggs_pkg::ROW_W'(1);
        end
        if (r_bv) begin
            r_pw0 <= q_c;
            r_pw1 <= q_p;
        end
    end

    // previous row around the column: q_m = c-1, q_c = c, q_p = c+1
    assign pb  = ~r_b_bank;
    assign q_c = r_b_col_zero ? r_first[pb] : r_pw1;
    assign q_m = r_pw0;
    assign q_p = ram_rdata[pb];
    assign q_b = ram_rdata[r_b_bank];

    always_comb begin
        o_push_ctl.has[ggs_pkg::SLOT_UP]   = r_b_up;
        o_push_ctl.has[ggs_pkg::SLOT_LEFT] = r_b_last_row && !r_b_col_zero;
        o_push_ctl.has[ggs_pkg::SLOT_LAST] = r_b_last_row && r_b_last_col;
        o_push_ctl.cx_up   = !r_b_col_zero && !r_b_last_col;
        o_push_ctl.cy_up   = !r_b_top2;
        o_push_ctl.cx_left = !r_b_col_one;
        o_push_ctl.col     = r_b_col;
        o_push_ctl.row     = r_b_row;

        if (r_b_col_zero) begin
            o_push_diff[ggs_pkg::D_UP_X] = f_diff(q_p, q_c);
        end else if (r_b_last_col) begin
            o_push_diff[ggs_pkg::D_UP_X] = f_diff(q_c, q_m);
        end else begin
            o_push_diff[ggs_pkg::D_UP_X] = f_diff(q_p, q_m);
        end
        o_push_diff[ggs_pkg::D_UP_Y]   = r_b_top2 ? f_diff(r_win[2], q_c)
                                                  : f_diff(r_win[2], q_b);
        o_push_diff[ggs_pkg::D_LEFT_X] = r_b_col_one ? f_diff(r_win[2], r_win[1])
                                                     : f_diff(r_win[2], r_win[0]);
        o_push_diff[ggs_pkg::D_LEFT_Y] = f_diff(r_win[1], q_m);
        o_push_diff[ggs_pkg::D_LAST_X] = f_diff(r_win[2], r_win[1]);
        o_push_diff[ggs_pkg::D_LAST_Y] = f_diff(r_win[2], q_c);
    end

    assign o_push = r_bv && (o_push_ctl.has != '0);

endmodule

// ----- hw/rtl/ggs_queue.sv -----
`timescale 1ns / 1ps
// Job queue between the front end and the scaling back end.
module ggs_queue #(
    parameter int DW = 33
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  ggs_pkg::t_job_ctl                         i_push_ctl,
    input  logic [ggs_pkg::NUM_DIFF-1:0][DW-1:0]      i_push_diff,
    input  logic                                      i_pop,
    output ggs_pkg::t_job_ctl                         o_head_ctl,
    output logic [ggs_pkg::NUM_DIFF-1:0][DW-1:0]      o_head_diff,
    output logic [$clog2(ggs_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(ggs_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ggs_pkg::QUEUE_DEPTH + 1);

    ggs_pkg::t_job_ctl                    r_ctl  [ggs_pkg::QUEUE_DEPTH];
    logic [ggs_pkg::NUM_DIFF-1:0][DW-1:0] r_diff [ggs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                        r_wr;
    logic [PW-1:0]                        r_rd;
    logic [CW-1:0]                        r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(ggs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(ggs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr]  <= i_push_ctl;
            r_diff[r_wr] <= i_push_diff;
        end
    end

    assign o_head_ctl  = r_ctl[r_rd];
    assign o_head_diff = r_diff[r_rd];
    assign o_count     = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < CW'(ggs_pkg::QUEUE_DEPTH))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ggs_pkg::QUEUE_DEPTH))
        else $error("job queue count out of range");

endmodule

// ----- hw/rtl/ggs_scale.sv -----
`timescale 1ns / 1ps
// Scaling lane: difference times reciprocal step, rounded shift and saturation.
module ggs_scale #(
    parameter int DW            = 33,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [DW-1:0]              i_diff,
    input  logic [ggs_pkg::STEP_W-1:0] i_inv,
    input  logic                       i_central,
    output logic [ggs_pkg::GRAD_W-1:0] o_grad
);

    localparam int SW_ = ggs_pkg::STEP_W;
    localparam int H   = (DW + 1) / 2;
    localparam int HI  = DW - H;
    localparam int PW  = DW + SW_;
    localparam int GW  = ggs_pkg::GRAD_W;
    localparam logic [PW:0] RND_F = (PW + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [PW:0] RND_C = (PW + 1)'(1) << FRACTION_BITS;
    localparam logic [PW:0] LIM_P = ((PW + 1)'(1) << (GW - 1)) - (PW + 1)'(1);
    localparam logic [PW:0] LIM_N = (PW + 1)'(1) << (GW - 1);

    logic [3:0]        r_neg;
    logic [3:0]        r_cen;
    logic [DW-1:0]     r_mag;
    logic [H+SW_-1:0]  r_plo;
    logic [HI+SW_-1:0] r_phi;
    logic [PW-1:0]     r_prod;
    logic [PW:0]       r_rnd;
    logic [GW-1:0]     r_grad;

    logic [PW:0]       q;
    logic [PW:0]       limit;
    logic [PW:0]       q_sat;
    logic [GW-1:0]     q_mag;

    always_comb begin
        q     = r_cen[3] ? (r_rnd >> (FRACTION_BITS + 1)) : (r_rnd >> FRACTION_BITS);
        limit = r_neg[3] ? LIM_N : LIM_P;
        q_sat = (q > limit) ? limit : q;
        q_mag = q_sat[GW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= {r_neg[2:0], i_diff[DW-1]};
            r_cen  <= {r_cen[2:0], i_central};
            r_mag  <= i_diff[DW-1] ? ('0 - i_diff) : i_diff;
            r_plo  <= {{SW_{1'b0}}, r_mag[H-1:0]} * {{H{1'b0}}, i_inv};
            r_phi  <= {{SW_{1'b0}}, r_mag[DW-1:H]} * {{HI{1'b0}}, i_inv};
            r_prod <= PW'(r_plo) + (PW'(r_phi) << H);
            r_rnd  <= {1'b0, r_prod} + (r_cen[2] ? RND_C : RND_F);
            r_grad <= r_neg[3] ? ('0 - q_mag) : q_mag;
        end
    end

    assign o_grad = r_grad;

endmodule

// ----- hw/rtl/ggs_back.sv -----
`timescale 1ns / 1ps
// Back end: result issue from the job queue, two scaling lanes, output register.
module ggs_back #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [ggs_pkg::STEP_W-1:0]                 i_inv_x,
    input  logic [ggs_pkg::STEP_W-1:0]                 i_inv_y,
    input  logic                                       i_head_valid,
    input  ggs_pkg::t_job_ctl                          i_head_ctl,
    input  logic [ggs_pkg::NUM_DIFF-1:0][SAMPLE_WIDTH:0] i_head_diff,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic [ggs_pkg::GRAD_W-1:0]                 o_grad_x,
    output logic [ggs_pkg::GRAD_W-1:0]                 o_grad_y,
    output logic [ggs_pkg::COL_W-1:0]                  o_col_index,
    output logic [ggs_pkg::ROW_W-1:0]                  o_row_index,
    output logic                                       o_frame_end
);

    localparam int DW = SAMPLE_WIDTH + 1;

    typedef struct packed {
        logic [ggs_pkg::COL_W-1:0] col;
        logic [ggs_pkg::ROW_W-1:0] row;
        logic                      frame_end;
    } t_res_meta;

    logic                          en;
    logic                          issue;
    logic                          last;
    logic [ggs_pkg::NUM_SLOTS-1:0] remaining;
    logic [ggs_pkg::NUM_SLOTS-1:0] sel_mask;
    logic [1:0]                    slot;
    logic [DW-1:0]                 sel_dx;
    logic [DW-1:0]                 sel_dy;
    logic                          sel_cx;
    logic                          sel_cy;
    t_res_meta                     sel_meta;

    logic [ggs_pkg::NUM_SLOTS-1:0] r_done;
    logic [DW-1:0]                 r_s1_dx;
    logic [DW-1:0]                 r_s1_dy;
    logic                          r_s1_cx;
    logic                          r_s1_cy;
    t_res_meta                     r_meta [ggs_pkg::SCALE_LAT+1];
    logic [ggs_pkg::SCALE_LAT:0]   r_vld;

    assign en        = !r_vld[ggs_pkg::SCALE_LAT] || i_out_ready;
    assign issue     = en && i_head_valid;
    assign remaining = i_head_ctl.has & ~r_done;

    always_comb begin
        if (remaining[ggs_pkg::SLOT_UP]) begin
            slot = ggs_pkg::SLOT_UP;
        end else if (remaining[ggs_pkg::SLOT_LEFT]) begin
            slot = ggs_pkg::SLOT_LEFT;
        end else begin
            slot = ggs_pkg::SLOT_LAST;
        end
        sel_mask = ggs_pkg::NUM_SLOTS'(1) << slot;
        last     = (remaining & ~sel_mask) == '0;

        case (slot)
            ggs_pkg::SLOT_UP: begin
                sel_dx   = i_head_diff[ggs_pkg::D_UP_X];
                sel_dy   = i_head_diff[ggs_pkg::D_UP_Y];
                sel_cx   = i_head_ctl.cx_up;
                sel_cy   = i_head_ctl.cy_up;
                sel_meta = '{col: i_head_ctl.col,
                             row: i_head_ctl.row - ggs_pkg::ROW_W'(1),
                             frame_end: 1'b0};
            end
            ggs_pkg::SLOT_LEFT: begin
                sel_dx   = i_head_diff[ggs_pkg::D_LEFT_X];
                sel_dy   = i_head_diff[ggs_pkg::D_LEFT_Y];
                sel_cx   = i_head_ctl.cx_left;
                sel_cy   = 1'b0;
                sel_meta = '{col: i_head_ctl.col - ggs_pkg::COL_W'(1),
                             row: i_head_ctl.row,
                             frame_end: 1'b0};
            end
            default: begin
                sel_dx   = i_head_diff[ggs_pkg::D_LAST_X];
                sel_dy   = i_head_diff[ggs_pkg::D_LAST_Y];
                sel_cx   = 1'b0;
                sel_cy   = 1'b0;
                sel_meta = '{col: i_head_ctl.col,
                             row: i_head_ctl.row,
                             frame_end: 1'b1};
            end
        endcase
    end

    assign o_pop = issue && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_vld  <= '0;
        end else begin
            if (issue) begin
                r_done <= last ? '0 : (r_done | sel_mask);
            end
            if (en) begin
                r_vld <= {r_vld[ggs_pkg::SCALE_LAT-1:0], i_head_valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dx   <= sel_dx;
            r_s1_dy   <= sel_dy;
            r_s1_cx   <= sel_cx;
            r_s1_cy   <= sel_cy;
            r_meta[0] <= sel_meta;
            for (int k = 1; k <= ggs_pkg::SCALE_LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    ggs_scale #(
        .DW            (DW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale_x (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_diff    (r_s1_dx),
        .i_inv     (i_inv_x),
        .i_central (r_s1_cx),
        .o_grad    (o_grad_x)
    );

    ggs_scale #(
        .DW            (DW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale_y (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_diff    (r_s1_dy),
        .i_inv     (i_inv_y),
        .i_central (r_s1_cy),
        .o_grad    (o_grad_y)
    );

    assign o_out_valid = r_vld[ggs_pkg::SCALE_LAT];
    assign o_col_index = r_meta[ggs_pkg::SCALE_LAT].col;
    assign o_row_index = r_meta[ggs_pkg::SCALE_LAT].row;
    assign o_frame_end = r_meta[ggs_pkg::SCALE_LAT].frame_end;

endmodule

// ----- hw/rtl/grid_gradient_stencil_unit.sv -----
`timescale 1ns / 1ps
// Top level of the grid gradient stencil unit: configuration registers and block wiring.
//
// Streams a grid in raster order (x fastest) and returns the x and y gradient of every
// point, tagged with its column, row and a frame-end flag; results keep raster order but
// for the last two rows, which interleave. One sample is taken per clock while the job
// queue has room. A point's result leaves once the sample below it has arrived; during
// the last row each sample also releases up to two results of that row, and the output
// then runs at one result per clock unless the consumer stalls it, throttling the input
// through a four-job queue. Two row stores of MAX_COLUMNS entries each hold the previous
// two rows. Results are signed Q16.16, rounded half away from zero and saturated.
// Configuration writes must only be issued while the block is idle.
module grid_gradient_stencil_unit #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ggs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ggs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]        i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ggs_pkg::GRAD_W-1:0]     o_grad_x,
    output logic [ggs_pkg::GRAD_W-1:0]     o_grad_y,
    output logic [ggs_pkg::COL_W-1:0]      o_col_index,
    output logic [ggs_pkg::ROW_W-1:0]      o_row_index,
    output logic                           o_frame_end
);

    localparam int DW = SAMPLE_WIDTH + 1;
    localparam int CW = $clog2(ggs_pkg::QUEUE_DEPTH + 1);

    logic [ggs_pkg::COL_W-1:0]  r_x_panels;
    logic [ggs_pkg::ROW_W-1:0]  r_y_panels;
    logic [ggs_pkg::STEP_W-1:0] r_inv_step_x;
    logic [ggs_pkg::STEP_W-1:0] r_inv_step_y;

    logic                                 push;
    ggs_pkg::t_job_ctl                    push_ctl;
    logic [ggs_pkg::NUM_DIFF-1:0][DW-1:0] push_diff;
    logic                                 pop;
    ggs_pkg::t_job_ctl                    head_ctl;
    logic [ggs_pkg::NUM_DIFF-1:0][DW-1:0] head_diff;
    logic [CW-1:0]                        queue_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_panels   <= ggs_pkg::COL_W'(1023);
            r_y_panels   <= ggs_pkg::ROW_W'(1023);
            r_inv_step_x <= ggs_pkg::STEP_W'(65536);
            r_inv_step_y <= ggs_pkg::STEP_W'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ggs_pkg::CFG_X_PANELS:   r_x_panels   <= i_cfg_data[ggs_pkg::COL_W-1:0];
                ggs_pkg::CFG_Y_PANELS:   r_y_panels   <= i_cfg_data[ggs_pkg::ROW_W-1:0];
                ggs_pkg::CFG_INV_STEP_X: r_inv_step_x <= i_cfg_data[ggs_pkg::STEP_W-1:0];
                ggs_pkg::CFG_INV_STEP_Y: r_inv_step_y <= i_cfg_data[ggs_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ggs_front #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_x_panels    (r_x_panels),
        .i_y_panels    (r_y_panels),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_queue_count (queue_count),
        .o_push        (push),
        .o_push_ctl    (push_ctl),
        .o_push_diff   (push_diff)
    );

    ggs_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_ctl  (push_ctl),
        .i_push_diff (push_diff),
        .i_pop       (pop),
        .o_head_ctl  (head_ctl),
        .o_head_diff (head_diff),
        .o_count     (queue_count)
    );

    ggs_back #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_inv_x      (r_inv_step_x),
        .i_inv_y      (r_inv_step_y),
        .i_head_valid (queue_count != '0),
        .i_head_ctl   (head_ctl),
        .i_head_diff  (head_diff),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_col_index  (o_col_index),
        .o_row_index  (o_row_index),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the grid gradient stencil unit: directed frames, then random frames.
module tb_top;

    localparam int FRAC         = 16;
    localparam int MAXC         = 1024;
    localparam int SETTLE_TICKS = 32;
    localparam int LIMIT_NS     = 4_000_000;
    localparam int PHASE_ITEMS  = 70;
    localparam int NUM_ROWS     = 41;
    localparam int NUM_KNOWN    = 8;

    typedef struct packed {
        logic [ggs_pkg::GRAD_W-1:0] gx;
        logic [ggs_pkg::GRAD_W-1:0] gy;
        logic [ggs_pkg::COL_W-1:0]  col;
        logic [ggs_pkg::ROW_W-1:0]  row;
        logic                       fend;
    } t_grad_point;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [ggs_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                   data;
        logic [1:0]                    known;
    } t_script_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [ggs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ggs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [31:0]                    i_sample;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [ggs_pkg::GRAD_W-1:0]     o_grad_x;
    logic [ggs_pkg::GRAD_W-1:0]     o_grad_y;
    logic [ggs_pkg::COL_W-1:0]      o_col_index;
    logic [ggs_pkg::ROW_W-1:0]      o_row_index;
    logic                           o_frame_end;

    // shadow of the block: registers, row banks, window, position
    logic [ggs_pkg::COL_W-1:0]  x_panels;
    logic [ggs_pkg::ROW_W-1:0]  y_panels;
    logic [ggs_pkg::STEP_W-1:0] inv_x;
    logic [ggs_pkg::STEP_W-1:0] inv_y;
    logic signed [31:0]         line_buf [2*MAXC];
    logic signed [31:0]         win [3];
    int unsigned                col_cnt;
    int unsigned                row_cnt;

    t_grad_point due_points [$];
    int          fault_count = 0;
    int          in_idle     = 0;
    int          out_stall   = 0;

    int phase_idle  [4] = '{0, 76, 0, 9};
    int phase_stall [4] = '{0, 0, 76, 9};

    // saturating corners, zero panels and steps, a tall frame cut short, a wide row cut short
    t_script_row script [NUM_ROWS] = '{
        '{ROW_CFG,    ggs_pkg::CFG_X_PANELS,   32'd1,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_Y_PANELS,   32'd1,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_X, 32'h0001_0000,  2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_Y, 32'h0001_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h8000_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h7FFF_FFFF,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h7FFF_FFFF,  2'd1},
        '{ROW_SAMPLE, '0,                      32'h8000_0000,  2'd3},
        '{ROW_CFG,    ggs_pkg::CFG_X_PANELS,   32'd0,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_Y_PANELS,   32'd0,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_X, 32'd0,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_Y, 32'd0,          2'd0},
        '{ROW_SAMPLE, '0,                      32'h1234_5678,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFEDC_BA98,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_0001,  2'd1},
        '{ROW_SAMPLE, '0,                      32'hFFFF_FFFF,  2'd3},
        '{ROW_CFG,    ggs_pkg::CFG_X_PANELS,   32'd2,          2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_Y_PANELS,   32'd65535,      2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_X, 32'hFFFF_FFFF,  2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_INV_STEP_Y, 32'h0000_8000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0001_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFFFF_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_0003,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h7FFF_FFFF,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_0001,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFFFF_FFFF,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0002_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h8000_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_0005,  2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_Y_PANELS,   32'd3,          2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_0002,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFFFF_FFFD,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h4000_0000,  2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_X_PANELS,   32'd1023,       2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_Y_PANELS,   32'd1,          2'd0},
        '{ROW_SAMPLE, '0,                      32'h0003_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFFFD_0000,  2'd0},
        '{ROW_CFG,    ggs_pkg::CFG_X_PANELS,   32'd1,          2'd0},
        '{ROW_SAMPLE, '0,                      32'h0000_1234,  2'd0},
        '{ROW_SAMPLE, '0,                      32'h0001_0000,  2'd0},
        '{ROW_SAMPLE, '0,                      32'hFFFF_8000,  2'd0}
    };

    t_grad_point known_points [NUM_KNOWN] = '{
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0, 16'd0, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 10'd1, 16'd0, 1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 10'd0, 16'd1, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 10'd1, 16'd1, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 10'd0, 16'd0, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 10'd1, 16'd0, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 10'd0, 16'd1, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 10'd1, 16'd1, 1'b1}
    };

    grid_gradient_stencil_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_col_index (o_col_index),
        .o_row_index (o_row_index),
        .o_frame_end (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // diff * inv >> shift, round half away from zero, saturate to 32 bits
    function automatic logic [31:0] fixed_grad(input logic signed [33:0] diff,
                                               input logic [31:0] inv, input bit central);
        logic        neg;
        logic [33:0] mag;
        logic [95:0] acc;
        logic [95:0] lim;
        int          sh;
        neg = diff < 0;
        mag = neg ? -diff : diff;
        sh  = central ? FRAC + 1 : FRAC;
        acc = ({62'd0, mag} * {64'd0, inv} + (96'd1 << (sh - 1))) >> sh;
        lim = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (acc > lim) acc = lim;
        return neg ? 32'd0 - acc[31:0] : acc[31:0];
    endfunction

    function automatic logic signed [31:0] line_at(input logic bank, input int unsigned col);
        return line_buf[{bank, col[ggs_pkg::COL_W-1:0]}];
    endfunction

    function automatic void note_point(input logic [31:0] gx, gy,
                                       input int unsigned col, row, input logic fend);
        due_points.push_back('{gx, gy, col[ggs_pkg::COL_W-1:0], row[ggs_pkg::ROW_W-1:0], fend});
    endfunction

    // one accepted sample: advance the shadow and queue the points it releases
    function automatic void stencil_step(input logic signed [31:0] s);
        int unsigned        xl, yl, c, r;
        logic               b, pb;
        bit                 lc, lr, cx, cy;
        logic signed [33:0] dx, dy;
        xl = (x_panels == 0) ? 1 : x_panels;
        yl = (y_panels == 0) ? 1 : y_panels;
        c  = col_cnt;
        r  = row_cnt;
        b  = r[0];
        pb = ~b;
        lc = c >= xl;
        lr = r >= yl;
        win[0] = win[1];
        win[1] = win[2];
        win[2] = s;
        if (r >= 1) begin
            if (c == 0) begin
                dx = line_at(pb, 1) - line_at(pb, 0);
                cx = 0;
            end else if (lc) begin
                dx = line_at(pb, c) - line_at(pb, c - 1);
                cx = 0;
            end else begin
                dx = line_at(pb, c + 1) - line_at(pb, c - 1);
                cx = 1;
            end
            if (r == 1) begin
                dy = s - line_at(pb, c);
                cy = 0;
            end else begin
                dy = s - line_at(b, c);
                cy = 1;
            end
            note_point(fixed_grad(dx, inv_x, cx), fixed_grad(dy, inv_y, cy),
                       c, r - 1, 1'b0);
        end
        line_buf[{b, c[ggs_pkg::COL_W-1:0]}] = s;
        if (lr) begin
            if (c >= 1) begin
                cx = (c != 1);
                dx = cx ? win[2] - win[0] : win[2] - win[1];
                dy = win[1] - line_at(pb, c - 1);
                note_point(fixed_grad(dx, inv_x, cx), fixed_grad(dy, inv_y, 0),
                           c - 1, r, 1'b0);
            end
            if (lc) begin
                dx = win[2] - win[1];
                dy = win[2] - line_at(pb, c);
                note_point(fixed_grad(dx, inv_x, 0), fixed_grad(dy, inv_y, 0), c, r, 1'b1);
            end
        end
        if (lc) begin
            col_cnt = 0;
            row_cnt = lr ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            col_cnt = (c + 1) & 32'h3FF;
        end
    endfunction

    function automatic logic [31:0] rand_panels(input int top, input int w);
        int unsigned v;
        case ($urandom_range(9))
            0:       v = 0;
            1, 2:    v = $urandom_range(top, 5);
            default: v = $urandom_range(4, 1);
        endcase
        return ({$urandom()} << w) | v;
    endfunction

    function automatic logic [31:0] rand_step();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0001_0000;
            3, 4:    return $urandom_range(32'h0003_0000, 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3, 4, 5: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic await_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ggs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        await_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            ggs_pkg::CFG_X_PANELS:   x_panels = data[ggs_pkg::COL_W-1:0];
            ggs_pkg::CFG_Y_PANELS:   y_panels = data[ggs_pkg::ROW_W-1:0];
            ggs_pkg::CFG_INV_STEP_X: inv_x    = data;
            ggs_pkg::CFG_INV_STEP_Y: inv_y    = data;
        endcase
    endtask

    task automatic send_sample(input logic [31:0] s);
        if ($urandom_range(99) < in_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_grad_point seen;
        t_grad_point want;
        i_out_ready <= i_rst_n && ($urandom_range(99) >= out_stall);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_grad_x, o_grad_y, o_col_index, o_row_index, o_frame_end};
            if (due_points.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: gx %h gy %h col %0d row %0d end %b",
                             seen.gx, seen.gy, seen.col, seen.row, seen.fend);
            end else begin
                want = due_points.pop_front();
                if (seen.gx !== want.gx || seen.gy !== want.gy || seen.col !== want.col ||
                    seen.row !== want.row || seen.fend !== want.fend) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch exp/got: gx %h/%h gy %h/%h col %0d/%0d ",
                                  "row %0d/%0d end %b/%b"},
                                 want.gx, seen.gx, want.gy, seen.gy, want.col, seen.col,
                                 want.row, seen.row, want.fend, seen.fend);
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          held;
        int          next_known;
        int          sent;
        int          frame_len;
        int          eff_x;
        int          eff_y;
        logic [31:0] smp;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        x_panels = 10'd1023;
        y_panels = 16'd1023;
        inv_x    = 32'h0001_0000;
        inv_y    = 32'h0001_0000;
        foreach (line_buf[k]) line_buf[k] = '0;
        foreach (win[k]) win[k] = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        next_known = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (script[i].kind == ROW_CFG) begin
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_sample(script[i].data);
                held = due_points.size();
                stencil_step(script[i].data);
                if (script[i].known != 0) begin
                    while (due_points.size() > held) void'(due_points.pop_back());
                    repeat (script[i].known) begin
                        due_points.push_back(known_points[next_known]);
                        next_known++;
                    end
                end
            end
        end

        foreach (phase_idle[p]) begin
            in_idle   = phase_idle[p];
            out_stall = phase_stall[p];
            sent      = 0;
            while (sent < PHASE_ITEMS) begin
                write_reg(ggs_pkg::CFG_X_PANELS, rand_panels(12, ggs_pkg::COL_W));
                write_reg(ggs_pkg::CFG_Y_PANELS, rand_panels(8, ggs_pkg::ROW_W));
                write_reg(ggs_pkg::CFG_INV_STEP_X, rand_step());
                write_reg(ggs_pkg::CFG_INV_STEP_Y, rand_step());
                eff_x     = (x_panels == 0) ? 1 : x_panels;
                eff_y     = (y_panels == 0) ? 1 : y_panels;
                frame_len = (eff_x + 1) * (eff_y + 1);
                for (int k = 0; k < frame_len; k++) begin
                    if ($urandom_range(63) == 0) await_drain();
                    smp = rand_sample();
                    send_sample(smp);
                    stencil_step(smp);
                    sent++;
                end
            end
        end

        await_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fault_count == 0 && due_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ggs_pkg.sv
hw/rtl/ggs_ram.sv
hw/rtl/ggs_front.sv
hw/rtl/ggs_queue.sv
hw/rtl/ggs_scale.sv
hw/rtl/ggs_back.sv
hw/rtl/grid_gradient_stencil_unit.sv
test/tb_top.sv
